// ----- design/mbe_pkg.sv -----
// Shared types, constants and helpers for the escape-time pixel core.
// No dependencies; used by mbe_mul, mandelbrot_escape_pixel_core and the verification files.
`timescale 1ns / 1ps

package mbe_pkg;

  // Signed Q6.26 value and full-precision product
  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] prod_t;

  localparam prod_t FixMax = 64'sd2147483647;
  localparam prod_t FixMin = -64'sd2147483648;

  // |z|^2 escape threshold: 4.0 in Q6.26
  localparam logic signed [32:0] EscapeBound = 33'sd268435456;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ORIGIN_REAL = 3'd0,
    CFG_ORIGIN_IMAG = 3'd1,
    CFG_STEP_REAL   = 3'd2,
    CFG_STEP_IMAG   = 3'd3,
    CFG_ITER_LIMIT  = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] IterLimitReset = 16'd200;

  // Pixel colour, red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Clamp a wide signed value to the Q6.26 range
  function automatic fix_t sat32(prod_t v);
    fix_t r;
    if (v > FixMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < FixMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Sixteen-entry gradient followed by the inside colour
  function automatic rgb_t palette_color(logic [4:0] idx);
    rgb_t c;
    unique case (idx)
      5'd0:    c = '{blue: 8'd15,  green: 8'd30,  red: 8'd66};
      5'd1:    c = '{blue: 8'd26,  green: 8'd7,   red: 8'd25};
      5'd2:    c = '{blue: 8'd47,  green: 8'd1,   red: 8'd9};
      5'd3:    c = '{blue: 8'd73,  green: 8'd4,   red: 8'd4};
      5'd4:    c = '{blue: 8'd100, green: 8'd7,   red: 8'd0};
      5'd5:    c = '{blue: 8'd138, green: 8'd44,  red: 8'd12};
      5'd6:    c = '{blue: 8'd177, green: 8'd82,  red: 8'd24};
      5'd7:    c = '{blue: 8'd209, green: 8'd125, red: 8'd57};
      5'd8:    c = '{blue: 8'd229, green: 8'd181, red: 8'd134};
      5'd9:    c = '{blue: 8'd248, green: 8'd236, red: 8'd211};
      5'd10:   c = '{blue: 8'd191, green: 8'd233, red: 8'd241};
      5'd11:   c = '{blue: 8'd95,  green: 8'd201, red: 8'd248};
      5'd12:   c = '{blue: 8'd0,   green: 8'd170, red: 8'd255};
      5'd13:   c = '{blue: 8'd0,   green: 8'd128, red: 8'd204};
      5'd14:   c = '{blue: 8'd0,   green: 8'd87,  red: 8'd153};
      5'd15:   c = '{blue: 8'd3,   green: 8'd52,  red: 8'd106};
      default: c = '{blue: 8'd16,  green: 8'd16,  red: 8'd16};
    endcase
    return c;
  endfunction

endpackage

// ----- design/mandelbrot_escape_pixel_core.sv -----
// Escape-time pixel core: maps (column, row) to c and iterates z = z^2 + c.
// Depends on mbe_pkg and mbe_mul.
`timescale 1ns / 1ps

// One pixel at a time. Mapping the pixel to c steps through S_MAPR, S_MAPI, S_SNAP
// and S_INIT, and every iteration through S_TEST, S_ZI, S_ZR2 and S_ZI2, since
// zr*zi, zr^2 and zi^2 share one 32x32 multiplier. The input side is ready again
// the cycle after the result is loaded into the output register, and a finished
// result may wait at the output while the next pixel runs. The user must write
// registers with cfg_we_i only while no pixel is in flight; the core does not
// enforce this. Indexes past the list are ignored.
module mandelbrot_escape_pixel_core #(
  parameter int GRADIENT_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] column, [23:12] row
  // pixel result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue,
                                      // [39:24] escape_count
);

  localparam int PhW = (GRADIENT_LENGTH > 1) ? $clog2(GRADIENT_LENGTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MAPR, S_MAPI, S_SNAP, S_INIT, S_TEST, S_ZI, S_ZR2, S_ZI2, S_DONE
  } state_e;

  // Configuration registers
  mbe_pkg::fix_t origin_real_q, origin_imag_q;
  logic [30:0]   step_real_q, step_imag_q;
  logic [15:0]   limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q <= '0;
      origin_imag_q <= '0;
      step_real_q   <= '0;
      step_imag_q   <= '0;
      limit_q       <= mbe_pkg::IterLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbe_pkg::CFG_ORIGIN_REAL: origin_real_q <= cfg_data_i;
        mbe_pkg::CFG_ORIGIN_IMAG: origin_imag_q <= cfg_data_i;
        mbe_pkg::CFG_STEP_REAL:   step_real_q   <= cfg_data_i[30:0];
        mbe_pkg::CFG_STEP_IMAG:   step_imag_q   <= cfg_data_i[30:0];
        mbe_pkg::CFG_ITER_LIMIT:  limit_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Datapath and control state
  state_e         state_q;
  logic [11:0]    col_q, row_q;
  mbe_pkg::fix_t  cr_q, ci_q, zr_q, zi_q, zr2_q, zi2_q;
  logic [15:0]    count_q;
  logic [PhW-1:0] phase_q;
  logic           out_valid_q;
  logic [39:0]    out_data_q;

  // Shared multiplier
  mbe_pkg::fix_t  mul_a, mul_b;
  logic           mul_en;
  mbe_pkg::prod_t prod;

  mbe_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Operand select per sequencer step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = zr_q;
    mul_b  = zi_q;
    unique case (state_q)
      S_MAPR: begin
        mul_a = $signed({20'd0, col_q});
        mul_b = $signed({1'b0, step_real_q});
      end
      S_MAPI: begin
        mul_a = $signed({20'd0, row_q});
        mul_b = $signed({1'b0, step_imag_q});
      end
      S_TEST: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      S_ZI: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_ZR2: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Escape test and snap test
  logic signed [32:0] zsum;
  logic               run;
  logic signed [32:0] ci_sx;
  logic [32:0]        ci_mag;
  logic               snap;
  logic               hit;
  logic [4:0]         pal_idx;
  mbe_pkg::rgb_t      color;

  always_comb begin
    zsum    = {zr2_q[31], zr2_q} + {zi2_q[31], zi2_q};
    run     = (count_q < limit_q) && (zsum < mbe_pkg::EscapeBound);
    ci_sx   = {ci_q[31], ci_q};
    ci_mag  = ci_q[31] ? 33'(-ci_sx) : 33'(ci_sx);
    snap    = {ci_mag, 1'b0} < {3'd0, step_imag_q};
    hit     = (count_q == limit_q);
    pal_idx = hit ? 5'(GRADIENT_LENGTH) : 5'(phase_q);
    color   = mbe_pkg::palette_color(pal_idx);
  end

  // Output register takes the finished pixel once it is free or being drained
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Sequencer with registered datapath and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      cr_q        <= '0;
      ci_q        <= '0;
      zr_q        <= '0;
      zi_q        <= '0;
      zr2_q       <= '0;
      zi2_q       <= '0;
      count_q     <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            col_q   <= s_axis_tdata[11:0];
            row_q   <= s_axis_tdata[23:12];
            state_q <= S_MAPR;
          end
        end
        S_MAPR: state_q <= S_MAPI;
        S_MAPI: begin
          cr_q    <= mbe_pkg::sat32(mbe_pkg::prod_t'(origin_real_q) + prod);
          state_q <= S_SNAP;
        end
        S_SNAP: begin
          ci_q    <= mbe_pkg::sat32(mbe_pkg::prod_t'(origin_imag_q) + prod);
          state_q <= S_INIT;
        end
        S_INIT: begin
          // imaginary part within half a row of the axis goes to zero
          if (snap) begin
            ci_q <= '0;
          end
          zr_q    <= '0;
          zi_q    <= '0;
          zr2_q   <= '0;
          zi2_q   <= '0;
          count_q <= '0;
          phase_q <= '0;
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (run) begin
            zr_q    <= mbe_pkg::sat32(mbe_pkg::prod_t'(zr2_q) - mbe_pkg::prod_t'(zi2_q)
                                      + mbe_pkg::prod_t'(cr_q));
            count_q <= count_q + 16'd1;
            phase_q <= (phase_q == PhW'(GRADIENT_LENGTH - 1)) ? '0 : phase_q + 1'b1;
            state_q <= S_ZI;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_ZI: begin
          // 2*zr*zi + ci
          zi_q    <= mbe_pkg::sat32((prod >>> 25) + mbe_pkg::prod_t'(ci_q));
          state_q <= S_ZR2;
        end
        S_ZR2: begin
          zr2_q   <= mbe_pkg::sat32(prod >>> 26);
          state_q <= S_ZI2;
        end
        S_ZI2: begin
          zi2_q   <= mbe_pkg::sat32(prod >>> 26);
          state_q <= S_TEST;
        end
        S_DONE: begin
          // load once the output register is free or being drained
          if (out_load) begin
            out_data_q  <= {count_q, color};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a pixel was starting");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result raised outside the completion step");

  a_squares_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TEST |-> !zr2_q[31] && !zi2_q[31])
    else $error("squared magnitude went negative");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(phase_q) < GRADIENT_LENGTH)
    else $error("gradient phase out of range");

endmodule

// ----- design/mbe_mul.sv -----
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on mbe_pkg for the operand and product types.
`timescale 1ns / 1ps

module mbe_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  mbe_pkg::fix_t a_i,
  input  mbe_pkg::fix_t b_i,
  output mbe_pkg::prod_t p_o
);

  mbe_pkg::prod_t p_q;

  // One product per cycle, held until the next enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- verif/mbe_pixel_checker.sv -----
// Result checker for mandelbrot_escape_pixel_core: shadows the register writes,
// predicts escape count and colour per pixel and compares results in order.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_pixel_checker #(
  parameter int GRADIENT_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // register writes, as seen by the core
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // pixel channel
  input  logic        pixel_valid_i,
  input  logic        pixel_ready_i,
  input  logic [23:0] pixel_data_i,   // [11:0] column, [23:12] row
  // result channel
  input  logic        result_valid_i,
  input  logic        result_ready_i,
  input  logic [39:0] result_data_i,  // [7:0] red, [15:8] green, [23:16] blue,
                                      // [39:24] escape_count
  output int          mismatches_o,
  output int          pixels_in_flight_o
);

  localparam int FracBits    = 26;
  localparam int InsideShade = 16;

  // Same layout as the result tdata
  typedef struct packed {
    logic [15:0]   escape_count;
    mbe_pkg::rgb_t color;
  } pixel_result_t;

  // Gradient entries are {blue, green, red}; the last one marks points inside
  localparam mbe_pkg::rgb_t Gradient [17] = '{
    {8'd15,  8'd30,  8'd66},  {8'd26,  8'd7,   8'd25},  {8'd47,  8'd1,   8'd9},
    {8'd73,  8'd4,   8'd4},   {8'd100, 8'd7,   8'd0},   {8'd138, 8'd44,  8'd12},
    {8'd177, 8'd82,  8'd24},  {8'd209, 8'd125, 8'd57},  {8'd229, 8'd181, 8'd134},
    {8'd248, 8'd236, 8'd211}, {8'd191, 8'd233, 8'd241}, {8'd95,  8'd201, 8'd248},
    {8'd0,   8'd170, 8'd255}, {8'd0,   8'd128, 8'd204}, {8'd0,   8'd87,  8'd153},
    {8'd3,   8'd52,  8'd106}, {8'd16,  8'd16,  8'd16}
  };

  // Shadow copy of the register file
  mbe_pkg::fix_t origin_re;
  mbe_pkg::fix_t origin_im;
  logic [30:0]   step_re;
  logic [30:0]   step_im;
  logic [15:0]   iter_limit;

  pixel_result_t pending_pixels_q [$];
  int            results_seen;

  function automatic longint clamp_q626(longint v);
    if (v > mbe_pkg::FixMax) return mbe_pkg::FixMax;
    if (v < mbe_pkg::FixMin) return mbe_pkg::FixMin;
    return v;
  endfunction

  // Escape-time iteration in Q6.26, floor-truncated products, saturating
  function automatic pixel_result_t escape_time_pixel(logic [11:0] col, logic [11:0] row);
    longint        c_re, c_im, z_re, z_im, re_sq, im_sq;
    int unsigned   iters;
    int            shade;
    pixel_result_t res;
    c_re = clamp_q626(longint'(origin_re) + longint'(col) * longint'(step_re));
    c_im = clamp_q626(longint'(origin_im) + longint'(row) * longint'(step_im));
    // within half a row of the real axis: snap onto it
    if (2 * (c_im < 0 ? -c_im : c_im) < longint'(step_im)) c_im = 0;
    z_re  = 0;
    z_im  = 0;
    re_sq = 0;
    im_sq = 0;
    iters = 0;
    while (iters < iter_limit && re_sq + im_sq < mbe_pkg::EscapeBound) begin
      z_im  = clamp_q626(((z_re * z_im) >>> (FracBits - 1)) + c_im);
      z_re  = clamp_q626(re_sq - im_sq + c_re);
      re_sq = clamp_q626((z_re * z_re) >>> FracBits);
      im_sq = clamp_q626((z_im * z_im) >>> FracBits);
      iters++;
    end
    if (iters == iter_limit) shade = GRADIENT_LENGTH;
    else shade = iters % GRADIENT_LENGTH;
    if (shade > InsideShade) shade = InsideShade;
    res.escape_count = iters[15:0];
    res.color        = Gradient[shade];
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches_o++;
    $display("%0t ns: result %0d %s expected %0d, got %0d",
             $time, results_seen, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) note_mismatch(what, want, got);
  endtask

  // Track registers, queue predictions on pixel transactions, compare results
  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_result_t got;
    pixel_result_t want;
    if (!rst_ni) begin
      origin_re    = '0;
      origin_im    = '0;
      step_re      = '0;
      step_im      = '0;
      iter_limit   = mbe_pkg::IterLimitReset;
      results_seen = 0;
      mismatches_o = 0;
      pending_pixels_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mbe_pkg::CFG_ORIGIN_REAL: origin_re  = cfg_data_i;
          mbe_pkg::CFG_ORIGIN_IMAG: origin_im  = cfg_data_i;
          mbe_pkg::CFG_STEP_REAL:   step_re    = cfg_data_i[30:0];
          mbe_pkg::CFG_STEP_IMAG:   step_im    = cfg_data_i[30:0];
          mbe_pkg::CFG_ITER_LIMIT:  iter_limit = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (pixel_valid_i && pixel_ready_i)
        pending_pixels_q.push_back(escape_time_pixel(pixel_data_i[11:0], pixel_data_i[23:12]));
      if (result_valid_i && result_ready_i) begin
        got = result_data_i;
        if (pending_pixels_q.size() == 0) begin
          mismatches_o++;
          $display("%0t ns: result %h arrived with no pixel pending, expected none",
                   $time, result_data_i);
        end else begin
          want = pending_pixels_q.pop_front();
          check_field("red", 16'(want.color.red), 16'(got.color.red));
          check_field("green", 16'(want.color.green), 16'(got.color.green));
          check_field("blue", 16'(want.color.blue), 16'(got.color.blue));
          check_field("escape_count", want.escape_count, got.escape_count);
        end
        results_seen++;
      end
    end
    pixels_in_flight_o = pending_pixels_q.size();
  end

endmodule

// ----- verif/tb.sv -----
// Top of the escape-time pixel core testbench: clock, reset, register setup,
// pixel stimulus, result back-pressure and the verdict.
// Depends on mbe_pkg, mandelbrot_escape_pixel_core and mbe_pixel_checker.
`timescale 1ns / 1ps

module tb;

  localparam int          PixelCount = 1850;
  localparam int          IdleLimit  = 20000;
  localparam int          Unit       = 1 << 26;   // 1.0 in Q6.26
  localparam logic [11:0] MaxCoord   = 12'hfff;
  localparam logic [2:0]  CfgSpare   = 3'd7;      // index past the register list

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_index     = '0;
  logic [31:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [11:0] column, [23:12] row
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue,
                                     // [39:24] escape_count

  int          mismatches;
  int          in_flight;
  int          burst_left  = 0;
  bit          bursty      = 1'b1;
  int          idle_cycles = 0;
  logic [15:0] ready_mask  = 16'hffff;
  logic [9:0]  stall_tick  = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mandelbrot_escape_pixel_core #(
    .GRADIENT_LENGTH(16)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mbe_pixel_checker #(
    .GRADIENT_LENGTH(16)
  ) u_pixel_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .pixel_valid_i      (s_axis_tvalid),
    .pixel_ready_i      (s_axis_tready),
    .pixel_data_i       (s_axis_tdata),
    .result_valid_i     (m_axis_tvalid),
    .result_ready_i     (m_axis_tready),
    .result_data_i      (m_axis_tdata),
    .mismatches_o       (mismatches),
    .pixels_in_flight_o (in_flight)
  );

  // Result back-pressure: half of each window accepts every cycle,
  // the other half follows a mask redrawn per window
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '1) ready_mask <= 16'($urandom);
    m_axis_tready <= stall_tick[9] ? 1'b1 : ready_mask[stall_tick[3:0]];
  end

  // Watchdog on cycles without any transaction or register write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Write all five registers, after a stray write to an unused index
  task automatic program_view(input logic [31:0] o_re, input logic [31:0] o_im,
                              input logic [31:0] s_re, input logic [31:0] s_im,
                              input logic [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CfgSpare;
    cfg_data  <= $urandom;
    @(posedge clk_i);
    cfg_index <= mbe_pkg::CFG_ORIGIN_REAL;
    cfg_data  <= o_re;
    @(posedge clk_i);
    cfg_index <= mbe_pkg::CFG_ORIGIN_IMAG;
    cfg_data  <= o_im;
    @(posedge clk_i);
    cfg_index <= mbe_pkg::CFG_STEP_REAL;
    cfg_data  <= s_re;
    @(posedge clk_i);
    cfg_index <= mbe_pkg::CFG_STEP_IMAG;
    cfg_data  <= s_im;
    @(posedge clk_i);
    cfg_index <= mbe_pkg::CFG_ITER_LIMIT;
    cfg_data  <= {16'($urandom), lim};
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One pixel transaction; bursts of random length with gaps between them, or one unbroken burst while bursty is clear
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    if (burst_left <= 0) begin
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = bursty ? int'($urandom_range(1, 16)) : 1 << 30;
    end
    s_axis_tdata  <= {row, col};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) s_axis_tvalid <= 1'b0;
  endtask

  // Hold off the sender until every pixel in flight has its result
  task automatic wait_drained();
    if (burst_left > 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (in_flight != 0);
    @(posedge clk_i);
  endtask

  // Mostly inside the window, sometimes anywhere on the full index range
  function automatic logic [11:0] pick_coord(int span);
    if ($urandom_range(0, 99) < 85) return 12'($urandom_range(0, span - 1));
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 40));
    if (r < 92) return 16'($urandom_range(41, 256));
    return 16'($urandom_range(257, 1024));
  endfunction

  // Random view: mostly 64-pixel windows over the set, plus noise setups
  task automatic random_view(output int span);
    int          kind;
    logic [31:0] step;
    kind = $urandom_range(0, 9);
    span = 64;
    if (kind <= 6) begin
      step = $urandom_range(Unit / 256, Unit / 16);
      program_view(-(5 * Unit / 2) + int'($urandom_range(0, 3 * Unit)),
                   -(3 * Unit / 2) + int'($urandom_range(0, 2 * Unit)),
                   step, ($urandom_range(0, 3) == 0) ? $urandom_range(Unit / 256, Unit / 16)
                   : step, pick_limit());
    end else if (kind == 7) begin
      span = 4096;
      program_view($urandom, $urandom, $urandom, $urandom, 16'($urandom_range(1, 1024)));
    end else if (kind == 8) begin
      // real part of c at least 2.5: every pixel escapes at once, so the
      // largest limit stays cheap
      span = 4096;
      program_view($urandom_range(5 * Unit / 2, 32'h7fff_ffff), $urandom, $urandom,
                   $urandom, 16'hffff);
    end else begin
      program_view(-(5 * Unit / 2) + int'($urandom_range(0, 3 * Unit)), $urandom, '0,
                   ($urandom_range(0, 1) == 0) ? $urandom : '0,
                   16'($urandom_range(0, 2)));
    end
  endtask

  initial begin
    int sent;
    int phase_len;
    int span;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: zero steps put every pixel on the origin, which stays inside
    send_pixel('0, '0);
    send_pixel(MaxCoord, MaxCoord);
    send_pixel(MaxCoord, '0);
    send_pixel('0, MaxCoord);
    wait_drained();

    // Classic window, 1/64 per pixel; row 64 lands a quarter row above the axis
    program_view(-2 * Unit, -Unit + Unit / 256, Unit / 64, Unit / 64, 16'd64);
    send_pixel(12'd64, 12'd64);
    send_pixel(12'd64, 12'd63);
    send_pixel('0, '0);
    send_pixel(MaxCoord, MaxCoord);
    send_pixel(12'd100, 12'd70);
    send_pixel(12'd32, 12'd96);
    wait_drained();

    // Smallest limit; row 64 now a quarter row below the axis
    program_view(-Unit, -Unit - Unit / 256, Unit / 64, Unit / 64, 16'd1);
    send_pixel(12'd64, 12'd64);
    send_pixel(12'd64, 12'd63);
    send_pixel('0, '0);
    send_pixel(MaxCoord, MaxCoord);
    wait_drained();

    // Coordinate extremes and saturation, largest limit
    program_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'hffff);
    send_pixel('0, '0);
    send_pixel(MaxCoord, MaxCoord);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2048, 12'd1);
    wait_drained();

    program_view(32'h8000_0000, 32'h7fff_ffff, '0, 32'd1, 16'hffff);
    send_pixel('0, '0);
    send_pixel(MaxCoord, MaxCoord);
    wait_drained();

    // Zero limit: no iteration at all
    program_view('0, '0, Unit, Unit, '0);
    send_pixel(12'd5, 12'd7);
    send_pixel(MaxCoord, '0);
    wait_drained();

    // Random views, each followed by a full drain
    sent = 0;
    while (sent < PixelCount) begin
      random_view(span);
      bursty    = $urandom_range(0, 3) != 0;
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        send_pixel(pick_coord(span), pick_coord(span));
        sent++;
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
      wait_drained();
    end

    // Room for any stray result after the last one
    repeat (64) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- mandelbrot_escape_pixel_core.f -----
design/mbe_pkg.sv
design/mbe_mul.sv
design/mandelbrot_escape_pixel_core.sv
verif/mbe_pixel_checker.sv
verif/tb.sv
